// ===== src/ffa_pkg.sv =====
// Shared types, codes and constants of the first-fit block allocator.
// No dependencies.
package ffa_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int BLOCK_BYTES    = 64;
	localparam int BLK_SHIFT      = $clog2(BLOCK_BYTES);
	localparam int CFG_W          = 11;
	localparam int CFG_RESET      = 1024;
	localparam int REQ_W          = 17;
	localparam int OFS_W          = 16;
	localparam int BYTES_W        = 17;
	localparam int CNT_MAX_W      = 17;
	localparam int NEED_W         = 18;
	localparam int BYTES_MAX      = 131071;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RS_DONE    = 2'd0,
		RS_ZERO    = 2'd1,
		RS_NOROOM  = 2'd2,
		RS_IGNORED = 2'd3
	} res_status_t;

	typedef enum logic [1:0] {
		BS_FREE   = 2'd0,
		BS_USED   = 2'd1,
		BS_BORDER = 2'd2
	} blk_status_t;

	// classified request, front to back
	typedef struct packed {
		op_t                  op;
		logic                 zero;
		logic [NEED_W-1:0]    need;
		logic [CNT_MAX_W-1:0] idx;
	} cmd_t;

	// finished request, back to output stage
	typedef struct packed {
		res_status_t          status;
		logic [OFS_W-1:0]     offset;
		logic [CNT_MAX_W-1:0] used_cnt;
	} res_t;

endpackage

// ===== src/ffa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/ffa_front.sv =====
// Front end: takes request transfers, rounds sizes to blocks, turns offsets
// into block indexes, and queues the result for the back end. Uses ffa_pkg.
module ffa_front
	import ffa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  op_t              in_op,
	input  logic [REQ_W-1:0] in_req,
	input  logic [OFS_W-1:0] in_rel,
	input  logic             clearing,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  logic             cmd_ready
);
	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       new_cmd;
	logic       push, pop;

	always_comb begin
		new_cmd.op   = in_op;
		new_cmd.zero = (in_req == '0);
		new_cmd.need = NEED_W'((NEED_W'(in_req) + NEED_W'(BLOCK_BYTES - 1)) >> BLK_SHIFT);
		new_cmd.idx  = CNT_MAX_W'(in_rel >> BLK_SHIFT);
	end

	assign in_ready  = (count_q != 2'd2) && !clearing;
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== src/ffa_back.sv =====
// Back end: owns the block status RAM, runs the first-fit scan, marks runs,
// walks frees and keeps the used-block count. Uses ffa_pkg and ffa_ram.
module ffa_back
	import ffa_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int IDX_W = $clog2(NUM_BLOCKS),
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] managed,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_ready,
	output logic             res_valid,
	output res_t             res,
	input  logic             res_ready,
	output logic             clearing
);
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_MARK  = 7'b0001000,
		S_FCHK  = 7'b0010000,
		S_FWALK = 7'b0100000,
		S_REPLY = 7'b1000000
	} state_t;

	state_t            st_q;
	logic [CNT_W-1:0]  a_q, idx_s1, run_q, cur_q, used_q;
	logic              pend_s1;
	logic [NEED_W-1:0] need_q;
	logic [IDX_W-1:0]  w_q, first_q, end_q;
	res_status_t       status_q;
	logic [OFS_W-1:0]  off_q;

	logic              we;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [1:0]        wdata, rdata;
	logic [CNT_W-1:0]  run_n, nxt;
	logic [NEED_W-1:0] first_n;
	logic              walk_hit;

	ffa_ram #(.WIDTH(2), .DEPTH(NUM_BLOCKS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign run_n    = run_q + CNT_W'(1);
	assign nxt      = cur_q + CNT_W'(1);
	assign first_n  = NEED_W'(idx_s1) + NEED_W'(1) - need_q;
	// in the check state the block must be a border, further on a used block
	assign walk_hit = (st_q == S_FCHK) ? (rdata == BS_BORDER) : (rdata == BS_USED);

	assign cmd_ready = (st_q == S_IDLE);
	assign clearing  = (st_q == S_CLEAR);
	assign res_valid = (st_q == S_REPLY);
	always_comb begin
		res.status   = status_q;
		res.offset   = off_q;
		res.used_cnt = CNT_MAX_W'(used_q);
	end

	always_comb begin
		we    = 1'b0;
		waddr = w_q;
		wdata = BS_FREE;
		raddr = a_q[IDX_W-1:0];
		unique case (st_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				raddr = cmd.idx[IDX_W-1:0];
			end
			S_MARK: begin
				we    = 1'b1;
				wdata = (w_q == first_q) ? BS_BORDER : BS_USED;
			end
			S_FCHK, S_FWALK: begin
				waddr = cur_q[IDX_W-1:0];
				we    = walk_hit;
				raddr = nxt[IDX_W-1:0];
			end
			S_SCAN, S_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				a_q     <= '0;
				run_q   <= '0;
				pend_s1 <= 1'b0;
				need_q  <= cmd.need;
				cur_q   <= CNT_W'(cmd.idx);
				off_q   <= '0;
			end
			S_SCAN: begin
				pend_s1 <= (a_q < managed);
				idx_s1  <= a_q;
				if (a_q < managed) a_q <= a_q + CNT_W'(1);
				if (pend_s1) begin
					if (rdata == BS_FREE) begin
						run_q <= run_n;
						if (NEED_W'(run_n) == need_q) begin
							first_q <= first_n[IDX_W-1:0];
							end_q   <= idx_s1[IDX_W-1:0];
						end
					end else begin
						run_q <= '0;
					end
				end
			end
			S_MARK: begin
				if (w_q == end_q) off_q <= OFS_W'(32'(first_q) << BLK_SHIFT);
			end
			S_FCHK, S_FWALK: begin
				if (walk_hit) cur_q <= nxt;
			end
			S_CLEAR, S_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			w_q      <= '0;
			used_q   <= '0;
			status_q <= RS_DONE;
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					w_q <= w_q + IDX_W'(1);
					if (w_q == IDX_W'(NUM_BLOCKS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						status_q <= RS_DONE;
						if (cmd.op == OP_ALLOC) begin
							if (cmd.zero) begin
								status_q <= RS_ZERO;
								st_q     <= S_REPLY;
							end else begin
								st_q <= S_SCAN;
							end
						end else if (cmd.idx >= CNT_MAX_W'(managed)) begin
							status_q <= RS_IGNORED;
							st_q     <= S_REPLY;
						end else begin
							st_q <= S_FCHK;
						end
					end
				end
				S_SCAN: begin
					if (pend_s1) begin
						if (rdata == BS_FREE && NEED_W'(run_n) == need_q) begin
							w_q    <= first_n[IDX_W-1:0];
							used_q <= CNT_W'(NEED_W'(used_q) + need_q);
							st_q   <= S_MARK;
						end
					end else if (a_q >= managed) begin
						status_q <= RS_NOROOM;
						st_q     <= S_REPLY;
					end
				end
				S_MARK: begin
					w_q <= w_q + IDX_W'(1);
					if (w_q == end_q) st_q <= S_REPLY;
				end
				S_FCHK, S_FWALK: begin
					if (walk_hit) begin
						if (used_q != '0) used_q <= used_q - CNT_W'(1);
						if (nxt >= managed) st_q <= S_REPLY;
						else                st_q <= S_FWALK;
					end else begin
						if (st_q == S_FCHK) status_q <= RS_IGNORED;
						st_q <= S_REPLY;
					end
				end
				S_REPLY: begin
					if (res_ready) st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== src/first_fit_block_allocator_core.sv =====
// First-fit block allocator core: front classifier, two-entry queue, back end
// with the block status RAM, output register. Uses ffa_pkg, ffa_front, ffa_back.
// An allocate scans for a fitting run of free blocks and then marks it; a free checks the
// border and walks the released blocks. The back end works on one request at a time.
// Reset clears control state, then a clearing pass over all NUM_BLOCKS entries holds s_axis_tready low.
module first_fit_block_allocator_core
	import ffa_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,     // managed block count (blocks_in_use)
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,  // request_bytes[16:0], release_offset[32:17]
	input  logic             s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [55:0]      m_axis_tdata   // status, alloc_offset, used_bytes, free_bytes
);
	logic [CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0] managed;
	logic             cmd_valid, cmd_ready, res_valid, res_ready, clearing;
	cmd_t             cmd;
	res_t             res;
	logic [CNT_MAX_W-1:0] free_cnt;
	logic [BYTES_W-1:0]   used_b, free_b;

	function automatic logic [BYTES_W-1:0] to_bytes(input logic [CNT_MAX_W-1:0] blocks);
		logic [47:0] b;
		b = 48'(blocks) << BLK_SHIFT;
		return (b > 48'(BYTES_MAX)) ? BYTES_W'(BYTES_MAX) : b[BYTES_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// registers above the built capacity act as the capacity
	assign managed = (32'(cfg_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(cfg_q);

	ffa_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(op_t'(s_axis_tuser)), .in_req(s_axis_tdata[16:0]),
		.in_rel(s_axis_tdata[32:17]),
		.clearing(clearing),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	ffa_back #(.NUM_BLOCKS(NUM_BLOCKS)) u_back (
		.clk(clk), .arst_n(arst_n), .managed(managed),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready),
		.res_valid(res_valid), .res(res), .res_ready(res_ready),
		.clearing(clearing)
	);

	// byte figures; blocks beyond a shrunk range stay counted, free floors at zero
	assign free_cnt = (CNT_MAX_W'(managed) > res.used_cnt) ?
		CNT_MAX_W'(managed) - res.used_cnt : '0;
	assign used_b   = to_bytes(res.used_cnt);
	assign free_b   = to_bytes(free_cnt);

	// output register: back end hands over while the previous result drains
	assign res_ready = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_axis_tdata <= {4'b0, free_b, used_b, res.offset, res.status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (res_ready) begin
			m_axis_tvalid <= res_valid;
		end
	end
endmodule

// ===== src/ffa_checker.sv =====
// Port-level checks for the allocator core, bound onto the top level.
// Uses ffa_pkg.
module ffa_checker
	import ffa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
		else $error("result changed while stalled");

	// offset only on a successful allocate
	a_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[17:2] != '0) |-> (m_axis_tdata[1:0] == RS_DONE))
		else $error("offset on a failed request");

	// used byte figure is whole blocks, unless saturated at BYTES_MAX
	a_gran: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[34:18] != 17'(BYTES_MAX)) |->
		(m_axis_tdata[18 +: BLK_SHIFT] == '0))
		else $error("used bytes not block aligned");
endmodule

bind first_fit_block_allocator_core ffa_checker u_ffa_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== test/tb_top.sv =====
// Testbench for first_fit_block_allocator_core: drives allocate and free requests,
// predicts each result from an own block status map, and checks every output transfer.
// Depends on ffa_pkg and the core RTL.
module tb_top;
	import ffa_pkg::*;

	typedef struct {
		op_t         op;
		logic [16:0] req;
		logic [15:0] rel;
	} request_t;

	typedef struct {
		res_status_t status;
		logic [15:0] offset;
		logic [16:0] used;
		logic [16:0] free;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;

	request_t    pending_requests[$];
	outcome_t    expected_results[$];
	blk_status_t block_map[1024];
	int unsigned blocks_taken = 0;
	logic [10:0] managed_setting = 11'd1024;
	bit          in_taken = 1'b0;
	bit          quiet = 1'b0;
	int          errors = 0;
	int          src_idle = 0;
	int          sink_idle = 0;

	first_fit_block_allocator_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [16:0] blocks_to_bytes(int unsigned n);
		longint unsigned b;
		b = longint'(n) * 64;
		return (b > 131071) ? 17'h1FFFF : b[16:0];
	endfunction

	// first-fit allocate or border release against the local block map
	function automatic outcome_t allocate_or_release(request_t r);
		outcome_t    o;
		int unsigned managed, need, run, first, idx;
		bit          found;
		managed = (managed_setting > 1024) ? 1024 : managed_setting;
		o.status = RS_DONE;
		o.offset = '0;
		found = 1'b0;
		if (r.op == OP_ALLOC) begin
			if (r.req == 0) begin
				o.status = RS_ZERO;
			end else begin
				need = (r.req + 63) / 64;
				run = 0;
				for (int i = 0; i < managed && !found; i++) begin
					if (block_map[i] == BS_FREE) begin
						run++;
						if (run == need) begin
							first = i + 1 - run;
							block_map[first] = BS_BORDER;
							for (int j = first + 1; j <= i; j++)
								block_map[j] = BS_USED;
							blocks_taken += need;
							o.offset = 16'(first * 64);
							found = 1'b1;
						end
					end else begin
						run = 0;
					end
				end
				if (!found)
					o.status = RS_NOROOM;
			end
		end else begin
			idx = r.rel / 64;
			if (idx >= managed || block_map[idx] != BS_BORDER) begin
				o.status = RS_IGNORED;
			end else begin
				block_map[idx] = BS_FREE;
				if (blocks_taken > 0) blocks_taken--;
				for (int i = idx + 1; i < managed && block_map[i] == BS_USED; i++) begin
					block_map[i] = BS_FREE;
					if (blocks_taken > 0) blocks_taken--;
				end
			end
		end
		o.used = blocks_to_bytes(blocks_taken);
		o.free = blocks_to_bytes((managed > blocks_taken) ? managed - blocks_taken : 0);
		return o;
	endfunction

	// input side: each accepted transfer is predicted at the edge it happens
	always @(posedge clk) begin
		request_t r;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (cfg_we)
			managed_setting = cfg_wdata;
		if (s_axis_tvalid && s_axis_tready) begin
			r.op  = op_t'(s_axis_tuser);
			r.req = s_axis_tdata[16:0];
			r.rel = s_axis_tdata[32:17];
			expected_results.push_back(allocate_or_release(r));
		end
	end

	// driver: new data at the falling edge, random idle bursts
	always @(negedge clk) begin
		request_t r;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (src_idle > 0) begin
				src_idle <= src_idle - 1;
				s_axis_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				src_idle <= $urandom_range(1, 15) - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				r = pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= r.op;
				s_axis_tdata  <= {7'b0, r.rel, r.req};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (sink_idle > 0) begin
			sink_idle <= sink_idle - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			sink_idle <= $urandom_range(1, 15) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: output transfer fields from bit 0 up: status, offset, used, free
	always @(posedge clk) begin
		outcome_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (m_axis_tdata[1:0] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
					errors++;
				end
				if (m_axis_tdata[17:2] !== e.offset) begin
					$error("alloc_offset: expected %0d, got %0d", e.offset, m_axis_tdata[17:2]);
					errors++;
				end
				if (m_axis_tdata[34:18] !== e.used) begin
					$error("used_bytes: expected %0d, got %0d", e.used, m_axis_tdata[34:18]);
					errors++;
				end
				if (m_axis_tdata[51:35] !== e.free) begin
					$error("free_bytes: expected %0d, got %0d", e.free, m_axis_tdata[51:35]);
					errors++;
				end
			end
		end
	end

	task automatic send(op_t op, logic [16:0] req, logic [15:0] rel);
		request_t r;
		r.op = op;
		r.req = req;
		r.rel = rel;
		pending_requests.push_back(r);
		while (pending_requests.size() > 0)
			@(negedge clk);
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic set_managed(logic [10:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small allocates and frees of live allocations, some noise
	task automatic random_mix(int n);
		int unsigned live[$];
		int unsigned pick, k;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			live = {};
			for (int b = 0; b < 1024; b++)
				if (block_map[b] == BS_BORDER) live.push_back(b);
			if (pick < 55) begin
				send(OP_ALLOC, 17'($urandom_range(1, 1500)), 16'($urandom));
			end else if (pick < 60) begin
				send(OP_ALLOC, 17'($urandom), 16'($urandom));
			end else if (pick < 92 && live.size() > 0) begin
				k = live[$urandom_range(0, live.size() - 1)];
				send(OP_FREE, 17'($urandom), 16'(k * 64 + $urandom_range(0, 63)));
			end else begin
				send(OP_FREE, 17'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		foreach (block_map[i]) block_map[i] = BS_FREE;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: size extremes, rounding, free corner cases
		send(OP_ALLOC, 17'd0, 16'hFFFF);
		send(OP_ALLOC, 17'd1, 16'd0);
		send(OP_ALLOC, 17'd64, 16'd0);
		send(OP_ALLOC, 17'd65, 16'd0);
		send(OP_FREE, 17'h1FFFF, 16'd64);    // border, unaligned offset not needed
		send(OP_FREE, 17'd0, 16'd64);        // now free, ignored
		send(OP_FREE, 17'd0, 16'd200);       // used block, not a border
		send(OP_FREE, 17'd0, 16'd130);       // unaligned offset inside border
		send(OP_FREE, 17'd0, 16'hFFFF);      // not a border
		send(OP_FREE, 17'd0, 16'd10);        // last live block, arena empty
		send(OP_ALLOC, 17'd65536, 16'd0);    // full managed range
		send(OP_ALLOC, 17'd1, 16'd0);        // no room
		send(OP_FREE, 17'd0, 16'd10);
		send(OP_ALLOC, 17'h1FFFF, 16'd0);    // beyond the range
		send(OP_ALLOC, 17'd65472, 16'd0);
		send(OP_ALLOC, 17'd64, 16'd0);
		send(OP_ALLOC, 17'd64, 16'd0);
		send(OP_FREE, 17'd0, 16'd0);
		send(OP_FREE, 17'd0, 16'd65472);
		random_mix(190);

		set_managed(11'd2047);               // oversized acts as full capacity
		random_mix(80);
		set_managed(11'd300);                // shrunk range with live blocks beyond
		random_mix(100);
		set_managed(11'd0);
		send(OP_ALLOC, 17'd1, 16'd0);
		send(OP_FREE, 17'd0, 16'd0);
		random_mix(8);
		set_managed(11'd1);
		send(OP_ALLOC, 17'd65, 16'd0);
		random_mix(20);
		set_managed(11'd1024);
		random_mix(40);
		quiet = 1'b1;
		random_mix(120);

		drain();
		repeat (2200) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#100000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
